// ----- rtl/local_alignment_score_core_defines.svh -----
// ---------------------------------------------------------------------------
// local_alignment_score_core_defines
// Assertion macros shared by the checker of the alignment score core.
// ---------------------------------------------------------------------------
`ifndef LOCAL_ALIGNMENT_SCORE_CORE_DEFINES_SVH
`define LOCAL_ALIGNMENT_SCORE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LAS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define LAS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/las_pkg.sv -----
// ---------------------------------------------------------------------------
// las_pkg
// Types, sizes and helpers of the local alignment score core.
// ---------------------------------------------------------------------------
package las_pkg;

    localparam int MAX_REF_LEN   = 256;
    localparam int MAX_QUERY_LEN = 1024;
    localparam int SCORE_BITS    = 15;
    localparam int CFG_W         = 6;
    localparam int SYM_W         = 8;

    localparam int REF_AW    = $clog2(MAX_REF_LEN);
    localparam int LEN_W     = $clog2(MAX_REF_LEN + 1);
    localparam int ROW_W     = $clog2(MAX_QUERY_LEN + 1);
    localparam int SUM_W     = SCORE_BITS + 2;
    localparam int SCORE_MAX = (1 << SCORE_BITS) - 1;

    typedef logic [SCORE_BITS-1:0] t_score;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        CFG_MATCH    = 2'd0,
        CFG_MISMATCH = 2'd1,
        CFG_GAP      = 2'd2
    } t_cfg_idx;

    localparam logic signed [CFG_W-1:0] MATCH_RST    = 6'sd2;
    localparam logic signed [CFG_W-1:0] MISMATCH_RST = -6'sd1;
    localparam logic signed [CFG_W-1:0] GAP_RST      = -6'sd2;

    typedef struct packed {
        t_req              req_type;
        logic [SYM_W-1:0]  symbol;
        logic              last;
    } t_in_item;

    typedef struct packed {
        t_score            best_score;
        logic [ROW_W-1:0]  best_row;
        logic [LEN_W-1:0]  best_col;
        logic              length_error;
    } t_out_item;

    typedef struct packed {
        logic signed [CFG_W-1:0] match;
        logic signed [CFG_W-1:0] mismatch;
        logic signed [CFG_W-1:0] gap;
    } t_scores;

    // one query row travelling down the chain
    typedef struct packed {
        logic              valid;
        logic              compute;
        logic              last;
        logic              ovf;
        logic [SYM_W-1:0]  sym;
        logic [ROW_W-1:0]  row;
    } t_token;

    typedef struct packed {
        t_token            tok;
        t_score            left;
        t_score            diag;
        t_score            best;
        logic [LEN_W-1:0]  best_col;
    } t_wave;

    // reference load broadcast to all cells
    typedef struct packed {
        logic               clear;
        logic               we;
        logic [REF_AW-1:0]  waddr;
        logic [SYM_W-1:0]   sym;
    } t_load;

    function automatic logic signed [SUM_W-1:0] sext_cfg(logic signed [CFG_W-1:0] x);
        return {{(SUM_W - CFG_W){x[CFG_W-1]}}, x};
    endfunction

    function automatic logic signed [SUM_W-1:0] zext_score(t_score x);
        return {2'b00, x};
    endfunction

endpackage

// ----- rtl/local_alignment_score_core.sv -----
// ---------------------------------------------------------------------------
// local_alignment_score_core
// Linear-gap local alignment score engine built as a systolic column chain.
// ---------------------------------------------------------------------------
// Reference symbols are loaded first (req_type 0), one per transaction, into
// a chain of MAX_REF_LEN cells; each query symbol (req_type 1) then computes
// one matrix row as a wavefront that moves one cell per cycle while the chain
// is not stalled. Query symbols are accepted one per cycle, back to back,
// unless the chain stalls. The result of a query passes through the injection
// register, which loads at the accepting edge, then one register per cell and
// the output register.
// A reference load is accepted only when no query row is still in the chain,
// so the first load after a query run waits for the chain to drain, and
// longer while a result is held at the output; consecutive loads are
// accepted back to back. The chain stalls only while a result waits at the
// output and another one reaches the chain end.
// Configuration writes take effect at once and belong to idle periods.
// ---------------------------------------------------------------------------
module local_alignment_score_core import las_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    localparam int INFL_W = $clog2(MAX_REF_LEN + 3);

    // configuration
    t_scores             r_cfg, n_cfg;

    // injection stage and bookkeeping
    t_wave               r_inj, n_inj;
    logic [ROW_W-1:0]    r_qcount, n_qcount;
    logic [LEN_W-1:0]    r_len, n_len;
    logic                r_ovf, n_ovf;
    logic                r_loading, n_loading;
    logic [INFL_W-1:0]   r_inflight, n_inflight;

    // running best over finished rows
    t_score              r_best, n_best;
    logic [ROW_W-1:0]    r_best_row, n_best_row;
    logic [LEN_W-1:0]    r_best_col, n_best_col;

    // result register
    t_out_item           r_out, n_out;
    logic                r_out_valid, n_out_valid;

    t_wave               w_end;
    t_load               w_load;
    logic                en, drained, acc_q, acc_l, qfull, fresh, upd;
    logic [LEN_W-1:0]    eff_len;
    logic                eff_ovf;
    t_score              u_best;
    logic [ROW_W-1:0]    u_row;
    logic [LEN_W-1:0]    u_col;

    always_comb begin
        n_cfg       = r_cfg;
        n_inj       = r_inj;
        n_qcount    = r_qcount;
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_loading   = r_loading;
        n_best      = r_best;
        n_best_row  = r_best_row;
        n_best_col  = r_best_col;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_load      = '0;

        // stall only when a result reaches the chain end with the output full
        en      = !(w_end.tok.valid && w_end.tok.last && r_out_valid && !i_out_ready);
        drained = (r_inflight == '0);

        o_in_ready = (i_in.req_type == REQ_QUERY) ? en : drained;
        acc_q = i_in_valid && o_in_ready && (i_in.req_type == REQ_QUERY);
        acc_l = i_in_valid && o_in_ready && (i_in.req_type == REQ_LOAD);

        // --- configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MATCH:    n_cfg.match    = i_cfg_data;
                CFG_MISMATCH: n_cfg.mismatch = i_cfg_data;
                CFG_GAP:      n_cfg.gap      = i_cfg_data;
                default:      n_cfg          = r_cfg;
            endcase
        end

        // --- query injection; rows past the limit travel as empty tokens
        qfull = (r_qcount >= ROW_W'(MAX_QUERY_LEN));
        if (en) begin
            n_inj             = '0;
            n_inj.tok.valid   = acc_q;
            n_inj.tok.compute = !qfull;
            n_inj.tok.last    = i_in.last;
            n_inj.tok.ovf     = r_ovf || qfull;
            n_inj.tok.sym     = i_in.symbol;
            n_inj.tok.row     = r_qcount + ROW_W'(1);
        end
        if (acc_q) begin
            if (qfull) begin
                n_ovf = 1'b1;
            end else begin
                n_qcount = r_qcount + ROW_W'(1);
            end
            if (i_in.last) begin
                n_qcount = '0;
            end
        end

        // --- reference load; a fresh load restarts everything
        fresh   = r_loading;
        eff_len = fresh ? '0 : r_len;
        eff_ovf = fresh ? 1'b0 : r_ovf;
        if (acc_l) begin
            w_load.clear = fresh;
            w_load.waddr = eff_len[REF_AW-1:0];
            w_load.sym   = i_in.symbol;
            n_len        = eff_len;
            n_ovf        = eff_ovf;
            if (eff_len < LEN_W'(MAX_REF_LEN)) begin
                w_load.we = 1'b1;
                n_len     = eff_len + LEN_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
            if (fresh) begin
                n_qcount   = '0;
                n_best     = '0;
                n_best_row = '0;
                n_best_col = '0;
            end
            n_loading = i_in.last;
        end

        // --- output handshake
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // --- rows leave the chain in order; strict compare keeps the first max
        upd    = w_end.tok.compute && (w_end.best > r_best);
        u_best = upd ? w_end.best     : r_best;
        u_row  = upd ? w_end.tok.row  : r_best_row;
        u_col  = upd ? w_end.best_col : r_best_col;
        if (en && w_end.tok.valid) begin
            if (w_end.tok.last) begin
                n_out.best_score   = u_best;
                n_out.best_row     = u_row;
                n_out.best_col     = u_col;
                n_out.length_error = w_end.tok.ovf;
                n_out_valid        = 1'b1;
                n_best             = '0;
                n_best_row         = '0;
                n_best_col         = '0;
            end else begin
                n_best     = u_best;
                n_best_row = u_row;
                n_best_col = u_col;
            end
        end

        n_inflight = r_inflight + INFL_W'(acc_q) - INFL_W'(en && w_end.tok.valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match    <= MATCH_RST;
            r_cfg.mismatch <= MISMATCH_RST;
            r_cfg.gap      <= GAP_RST;
            r_inj          <= '0;
            r_qcount       <= '0;
            r_len          <= '0;
            r_ovf          <= 1'b0;
            r_loading      <= 1'b1;
            r_inflight     <= '0;
            r_best         <= '0;
            r_best_row     <= '0;
            r_best_col     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_cfg          <= n_cfg;
            r_inj          <= n_inj;
            r_qcount       <= n_qcount;
            r_len          <= n_len;
            r_ovf          <= n_ovf;
            r_loading      <= n_loading;
            r_inflight     <= n_inflight;
            r_best         <= n_best;
            r_best_row     <= n_best_row;
            r_best_col     <= n_best_col;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    las_array u_array (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_load  (w_load),
        .i_wave  (r_inj),
        .o_wave  (w_end)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- rtl/las_cell.sv -----
// ---------------------------------------------------------------------------
// las_cell
// One reference column: holds its symbol and the score of the row above,
// computes one matrix cell per passing row and forwards the wavefront.
// ---------------------------------------------------------------------------
module las_cell import las_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [REF_AW-1:0]  i_idx,
    input  t_scores            i_cfg,
    input  t_load              i_load,
    input  t_wave              i_wave,
    output t_wave              o_wave
);

    localparam logic signed [SUM_W-1:0] SAT  = SUM_W'(SCORE_MAX);
    localparam logic signed [SUM_W-1:0] ZERO = '0;

    logic [SYM_W-1:0]         r_sym;
    logic                     r_active;
    t_score                   r_h;
    t_wave                    r_wave;

    t_wave                    n_wave;
    t_score                   v_sat;
    logic signed [SUM_W-1:0]  d_sum, l_sum, u_sum, m1, m2, m_all;
    logic                     do_calc;

    always_comb begin
        d_sum = zext_score(i_wave.diag)
              + sext_cfg((r_sym == i_wave.tok.sym) ? i_cfg.match : i_cfg.mismatch);
        l_sum = zext_score(i_wave.left) + sext_cfg(i_cfg.gap);
        u_sum = zext_score(r_h) + sext_cfg(i_cfg.gap);
        m1    = (d_sum > l_sum) ? d_sum : l_sum;
        m2    = (u_sum > ZERO) ? u_sum : ZERO;
        m_all = (m1 > m2) ? m1 : m2;
        v_sat = (m_all > SAT) ? t_score'(SCORE_MAX) : m_all[SCORE_BITS-1:0];

        do_calc = i_wave.tok.valid && i_wave.tok.compute && r_active;

        n_wave      = i_wave;
        n_wave.diag = r_h;
        if (do_calc) begin
            n_wave.left = v_sat;
            // strict compare keeps the first column reaching the row maximum
            if (v_sat > i_wave.best) begin
                n_wave.best     = v_sat;
                n_wave.best_col = {1'b0, i_idx} + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_h      <= '0;
            r_wave   <= '0;
        end else begin
            if (i_en) begin
                r_wave <= n_wave;
                if (do_calc) begin
                    r_h <= v_sat;
                end
                if (i_wave.tok.valid && i_wave.tok.last) begin
                    r_h <= '0;
                end
            end
            if (i_load.clear) begin
                r_h      <= '0;
                r_active <= 1'b0;
            end
            if (i_load.we && (i_load.waddr == i_idx)) begin
                r_active <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.we && (i_load.waddr == i_idx)) begin
            r_sym <= i_load.sym;
        end
    end

    assign o_wave = r_wave;

endmodule

// ----- rtl/las_array.sv -----
// ---------------------------------------------------------------------------
// las_array
// Linear chain of MAX_REF_LEN cells, one per reference position.
// ---------------------------------------------------------------------------
module las_array import las_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_scores  i_cfg,
    input  t_load    i_load,
    input  t_wave    i_wave,
    output t_wave    o_wave
);

    t_wave w_chain [0:MAX_REF_LEN];

    assign w_chain[0] = i_wave;

    for (genvar g = 0; g < MAX_REF_LEN; g++) begin : g_col
        las_cell u_col (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_idx   (REF_AW'(g)),
            .i_cfg   (i_cfg),
            .i_load  (i_load),
            .i_wave  (w_chain[g]),
            .o_wave  (w_chain[g+1])
        );
    end

    assign o_wave = w_chain[MAX_REF_LEN];

endmodule

// ----- rtl/las_checker.sv -----
// ---------------------------------------------------------------------------
// las_checker
// Port-level checks of the alignment score core, bound to the top level.
// ---------------------------------------------------------------------------
`include "local_alignment_score_core_defines.svh"

module las_checker import las_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  t_in_item           i_in,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  t_out_item          o_out,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    logic load_acc;

    assign load_acc = i_in_valid && o_in_ready && (i_in.req_type == REQ_LOAD);

    // held transaction must not change
    `LAS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out), "result changed while stalled")

    // loads are taken only with the chain empty, so no result can follow
    `LAS_ASSERT_NEXT(a_load_quiet, load_acc && !o_out_valid, !o_out_valid, "result right after a load")

    // a zero score can only sit at the origin
    `LAS_ASSERT_NOW(a_zero_origin, o_out_valid && (o_out.best_score == '0), (o_out.best_row == '0) && (o_out.best_col == '0), "zero score off origin")

    // row and column are both set or both clear
    `LAS_ASSERT_NOW(a_pos_pair, o_out_valid, (o_out.best_row == '0) == (o_out.best_col == '0), "row and column disagree")

endmodule

bind local_alignment_score_core las_checker u_las_checker (.*);
